>>> sv/dspc_pkg.sv
// Shared types, constants and helpers for the dual sensor plausibility check.
package dspc_pkg;

	// Sample and register widths
	localparam int SAMPLE_BITS = 12;
	localparam int CFG_W       = 12;
	localparam int COUNT_W     = 6;
	localparam int IDX_W       = 3;

	// Range status codes
	localparam logic [1:0] RANGE_OK   = 2'd0;
	localparam logic [1:0] RANGE_HIGH = 2'd1;
	localparam logic [1:0] RANGE_LOW  = 2'd2;

	// Register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_HIGH_LIMIT  = 3'd0,
		REG_LOW_LIMIT   = 3'd1,
		REG_DIFF_LIMIT  = 3'd2,
		REG_SET_COUNT   = 3'd3,
		REG_CLEAR_COUNT = 3'd4
	} reg_idx_t;

	// Reset values
	localparam logic [CFG_W-1:0]   HIGH_LIMIT_RST  = 12'd4095;
	localparam logic [CFG_W-1:0]   LOW_LIMIT_RST   = 12'd0;
	localparam logic [CFG_W-1:0]   DIFF_LIMIT_RST  = 12'd161;
	localparam logic [COUNT_W-1:0] SET_COUNT_RST   = 6'd30;
	localparam logic [COUNT_W-1:0] CLEAR_COUNT_RST = 6'd15;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_W-1:0]     count_t;

	// Active configuration
	typedef struct packed {
		sample_t          high_limit;
		sample_t          low_limit;
		logic [CFG_W-1:0] diff_limit;
		count_t           set_count;
		count_t           clear_count;
	} cfg_t;

	// Check state, which is also the result payload
	typedef struct packed {
		logic [1:0] range_status;
		logic       fault;
		count_t     count;
	} chk_state_t;

	// Fit a register value to the sample width (truncate or zero extend)
	function automatic sample_t to_sample(input logic [CFG_W-1:0] v);
		logic [CFG_W+SAMPLE_BITS-1:0] t;
		t = {{SAMPLE_BITS{1'b0}}, v};
		return t[SAMPLE_BITS-1:0];
	endfunction

endpackage

>>> sv/dual_sensor_plausibility_check_unit.sv
// Top level of the dual sensor plausibility check.
//
// Input channel: sensor_a / sensor_b with sample_valid, sample_stall. One
// transfer carries one pair of averaged readings.
// Result channel: range_status, mismatch_fault, mismatch_count with
// result_valid, result_stall. Every input transfer gives one result.
// Config port: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while no item is in flight.
// Path: a pair goes through the input register, then into the state/result
// register, which shows its result.
// Throughput: one pair per cycle while the result is not stalled. The state
// update is a single compare and 7-bit count step between the input
// register and the state register, so consecutive pairs go through back to back.
// The state register is the result register: the result stays put while
// result_stall is high, and the input register still takes one more pair.
// sample_stall rises only when both registers are full and the result is
// stalled.
// Reset clears the range status, counter, fault flag and all valids, and
// loads the register defaults.
module dual_sensor_plausibility_check_unit
	import dspc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             sample_valid,
	output logic             sample_stall,
	input  sample_t          sensor_a,
	input  sample_t          sensor_b,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [1:0]       range_status,
	output logic             mismatch_fault,
	output count_t           mismatch_count
);

	cfg_t       cfg;
	logic       valid_s1;
	sample_t    a_s1;
	sample_t    b_s1;
	logic       result_valid_q;
	chk_state_t st_q;
	chk_state_t st_nxt;
	logic       advance;

	dspc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dspc_update u_update (
		.sensor_a (a_s1),
		.sensor_b (b_s1),
		.cfg      (cfg),
		.cur      (st_q),
		.nxt      (st_nxt)
	);

	// Flow control
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign sample_stall = valid_s1 && result_valid_q && result_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			a_s1 <= sensor_a;
			b_s1 <= sensor_b;
		end
	end

	// State / result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= '0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			st_q           <= st_nxt;
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid   = result_valid_q;
	assign range_status   = st_q.range_status;
	assign mismatch_fault = st_q.fault;
	assign mismatch_count = st_q.count;

	// Input side stalls only when the whole pipe is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("sample_stall without a blocked pipe");

	// A pair moving out of the input register shows up as a result
	a_advance_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid_q)
		else $error("advanced pair did not produce a result");

	// Range status never carries the unused code
	a_range_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (st_q.range_status == RANGE_OK ||
			st_q.range_status == RANGE_HIGH || st_q.range_status == RANGE_LOW))
		else $error("range status holds an unused code");

	// State changes only when a pair is processed
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(advance) |-> $stable(st_q))
		else $error("state changed without a processed pair");

endmodule

>>> sv/dspc_cfg.sv
// Configuration register file for the plausibility check.
module dspc_cfg
	import dspc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_limit  <= to_sample(HIGH_LIMIT_RST);
			cfg_q.low_limit   <= to_sample(LOW_LIMIT_RST);
			cfg_q.diff_limit  <= DIFF_LIMIT_RST;
			cfg_q.set_count   <= SET_COUNT_RST;
			cfg_q.clear_count <= CLEAR_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HIGH_LIMIT:  cfg_q.high_limit  <= to_sample(cfg_data);
				REG_LOW_LIMIT:   cfg_q.low_limit   <= to_sample(cfg_data);
				REG_DIFF_LIMIT:  cfg_q.diff_limit  <= cfg_data;
				REG_SET_COUNT:   cfg_q.set_count   <= cfg_data[COUNT_W-1:0];
				REG_CLEAR_COUNT: cfg_q.clear_count <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/dspc_update.sv
// Next-state logic: range status, disagreement counter and fault flag.
module dspc_update
	import dspc_pkg::*;
(
	input  sample_t    sensor_a,
	input  sample_t    sensor_b,
	input  cfg_t       cfg,
	input  chk_state_t cur,
	output chk_state_t nxt
);

	localparam int WIDE_W = CFG_W + SAMPLE_BITS;

	sample_t             diff;
	logic [WIDE_W-1:0]   diff_w;
	logic [WIDE_W-1:0]   lim_w;
	logic [COUNT_W:0]    cnt;
	logic                a_in;
	logic                b_in;

	// Absolute difference, compared at a common width
	assign diff   = (sensor_a > sensor_b) ? (sensor_a - sensor_b) : (sensor_b - sensor_a);
	assign diff_w = {{CFG_W{1'b0}}, diff};
	assign lim_w  = {{SAMPLE_BITS{1'b0}}, cfg.diff_limit};

	// Strictly between the limits
	assign a_in = (sensor_a < cfg.high_limit) && (sensor_a > cfg.low_limit);
	assign b_in = (sensor_b < cfg.high_limit) && (sensor_b > cfg.low_limit);

	always_comb begin
		nxt = cur;

		// Range status: low beats high, both inside clears, else hold
		if (sensor_a > cfg.high_limit || sensor_b > cfg.high_limit)
			nxt.range_status = RANGE_HIGH;
		if (sensor_a < cfg.low_limit || sensor_b < cfg.low_limit)
			nxt.range_status = RANGE_LOW;
		if (a_in && b_in)
			nxt.range_status = RANGE_OK;

		// Counter step, one extra bit for the increment past 63
		cnt = {1'b0, cur.count};
		if (diff_w > lim_w)
			cnt = cnt + 1'b1;
		else if (diff_w < lim_w && cur.count != '0)
			cnt = cnt - 1'b1;

		// Clamp and set, then clear on the clamped value
		if (cnt >= {1'b0, cfg.set_count}) begin
			nxt.fault = 1'b1;
			cnt       = {1'b0, cfg.set_count};
		end
		if (cnt < {1'b0, cfg.clear_count})
			nxt.fault = 1'b0;

		nxt.count = cnt[COUNT_W-1:0];
	end

endmodule
